### src/section_timing_profiler_macros.svh
// Assertion macros used by the checker file.
`ifndef SECTION_TIMING_PROFILER_MACROS_SVH
`define SECTION_TIMING_PROFILER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/stp_pkg.sv
package stp_pkg;

  localparam int NUM_SECTIONS_DEF   = 8;
  localparam int FIRST_USER_SECTION = 2;
  localparam int FRAME_SECTION      = 1;

  localparam int TIME_W    = 32;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = 32;
  localparam int FRAME_W   = 8;
  localparam int REC_IDX_W = 4;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;

  localparam logic [FRAME_W-1:0] BATCH_RESET = 8'd60;

  // Word address bit of the register map.
  localparam logic REG_BATCH_FRAMES = 1'b0;

  typedef enum logic [1:0] {
    OP_BEGIN       = 2'd0,
    OP_END         = 2'd1,
    OP_FRAME_BEGIN = 2'd2,
    OP_FRAME_END   = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic update;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic report_due;
    logic report_last;
  } dp_status_t;

endpackage

### src/section_timing_profiler.sv
// Section timing profiler. An event is transferred when start is high and
// busy is low; the accepting edge registers the event and its interval, and
// the S_UPDATE state then updates the statistics while busy is high, so the
// block cannot take a new event before it is through with the last one. A
// frame end that completes a batch keeps busy high while the report walks
// the section records and then the system record, one record per cycle.
// Each record is marked by result_strobe for exactly one cycle; the receiver
// cannot stall it, so it must take every record as it comes. batch_frames
// is written over the APB port at any address with paddr[2] low (0 to 3).
module section_timing_profiler
  import stp_pkg::*;
#(
  parameter int NUM_SECTIONS = NUM_SECTIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [2:0]           section,
  input  logic [TIME_W-1:0]    user_time,
  input  logic [TIME_W-1:0]    system_time,
  output logic                 result_strobe,
  output logic [REC_IDX_W-1:0] record_index,
  output logic [SUM_W-1:0]     total_ticks,
  output logic [TIME_W-1:0]    min_ticks,
  output logic [TIME_W-1:0]    max_ticks,
  output logic [CNT_W-1:0]     call_count,
  output logic [FRAME_W-1:0]   frames_done,
  output logic                 last_record,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]     pwdata,
  output logic [APB_W-1:0]     prdata,
  output logic                 pready
);

  logic [FRAME_W-1:0] batch_frames;
  ctrl_cmd_t          cmd;
  dp_status_t         status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_frames <= BATCH_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BATCH_FRAMES)) begin
      batch_frames <= pwdata[FRAME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BATCH_FRAMES) prdata = APB_W'(batch_frames);
  end

  stp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  stp_datapath #(
    .NUM_SECTIONS (NUM_SECTIONS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .batch_frames  (batch_frames),
    .opcode        (opcode),
    .section       (section),
    .user_time     (user_time),
    .system_time   (system_time),
    .result_strobe (result_strobe),
    .record_index  (record_index),
    .total_ticks   (total_ticks),
    .min_ticks     (min_ticks),
    .max_ticks     (max_ticks),
    .call_count    (call_count),
    .frames_done   (frames_done),
    .last_record   (last_record)
  );

endmodule

### src/stp_ctrl.sv
module stp_ctrl
  import stp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_REPORT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.update = (state == S_UPDATE);
    cmd.report = (state == S_REPORT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_UPDATE;
            busy  <= 1'b1;
          end
        end
        S_UPDATE: begin
          if (status.report_due) begin
            state <= S_REPORT;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_REPORT: begin
          if (status.report_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/stp_datapath.sv
module stp_datapath
  import stp_pkg::*;
#(
  parameter int NUM_SECTIONS = NUM_SECTIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic [FRAME_W-1:0]   batch_frames,
  input  logic [1:0]           opcode,
  input  logic [2:0]           section,
  input  logic [TIME_W-1:0]    user_time,
  input  logic [TIME_W-1:0]    system_time,
  output logic                 result_strobe,
  output logic [REC_IDX_W-1:0] record_index,
  output logic [SUM_W-1:0]     total_ticks,
  output logic [TIME_W-1:0]    min_ticks,
  output logic [TIME_W-1:0]    max_ticks,
  output logic [CNT_W-1:0]     call_count,
  output logic [FRAME_W-1:0]   frames_done,
  output logic                 last_record
);

  localparam int IW = $clog2(NUM_SECTIONS);
  localparam int RW = $clog2(NUM_SECTIONS + 1);

  // Per-section statistics.
  logic              open_flag   [NUM_SECTIONS];
  logic [TIME_W-1:0] open_time   [NUM_SECTIONS];
  logic [SUM_W-1:0]  sum_ticks   [NUM_SECTIONS];
  logic [TIME_W-1:0] least_ticks [NUM_SECTIONS];
  logic [TIME_W-1:0] most_ticks  [NUM_SECTIONS];
  logic [CNT_W-1:0]  hit_count   [NUM_SECTIONS];

  logic [TIME_W-1:0]  frame_start_user;
  logic [TIME_W-1:0]  frame_start_system;
  logic [SUM_W-1:0]   system_sum;
  logic [TIME_W-1:0]  system_least;
  logic [TIME_W-1:0]  system_most;
  logic [FRAME_W-1:0] frame_counter;
  logic [RW-1:0]      rep_idx;

  // Event latched at the accepting edge.
  op_t               op_q;
  logic [IW-1:0]     idx_q;
  logic              sec_ok_q;
  logic [TIME_W-1:0] ut_q;
  logic [TIME_W-1:0] st_q;
  logic [TIME_W-1:0] dt_q;
  logic [TIME_W-1:0] ds_q;

  op_t               op_in;
  logic              sec_ok;
  logic [IW-1:0]     sec_idx;
  logic [IW-1:0]     load_idx;
  logic [TIME_W-1:0] base_time;
  logic              add_en;
  logic [SUM_W-1:0]  sum_next;
  logic [FRAME_W-1:0] counter_inc;
  logic [IW-1:0]     rep_sel;

  always_comb begin
    op_in    = op_t'(opcode);
    sec_ok   = (section >= 3'(FIRST_USER_SECTION)) && (int'(section) < NUM_SECTIONS);
    sec_idx  = IW'(section);
    load_idx = (op_in == OP_FRAME_END) ? IW'(FRAME_SECTION) : sec_idx;
    // A frame end measures against the latched frame start, a section end
    // against the time the section was opened.
    base_time = (op_in == OP_FRAME_END) ? frame_start_user : open_time[sec_idx];
  end

  always_comb begin
    add_en = ((op_q == OP_END) && sec_ok_q && open_flag[idx_q]) ||
             (op_q == OP_FRAME_END);
    sum_next    = sum_ticks[idx_q] + SUM_W'(dt_q);
    counter_inc = frame_counter + 8'd1;
    rep_sel     = rep_idx[IW-1:0];
    status.report_due  = (op_q == OP_FRAME_END) && (counter_inc >= batch_frames);
    status.report_last = (rep_idx == RW'(NUM_SECTIONS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op_in;
      idx_q    <= load_idx;
      sec_ok_q <= sec_ok;
      ut_q     <= user_time;
      st_q     <= system_time;
      dt_q     <= user_time - base_time;
      ds_q     <= system_time - frame_start_system;
    end
    if (cmd.report) begin
      record_index <= REC_IDX_W'(rep_idx);
      frames_done  <= frame_counter;
      last_record  <= status.report_last;
      if (status.report_last) begin
        total_ticks <= system_sum;
        min_ticks   <= system_least;
        max_ticks   <= system_most;
        call_count  <= CNT_W'(frame_counter);
      end else begin
        total_ticks <= sum_ticks[rep_sel];
        min_ticks   <= least_ticks[rep_sel];
        max_ticks   <= most_ticks[rep_sel];
        call_count  <= hit_count[rep_sel];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        open_flag[i]   <= 1'b0;
        open_time[i]   <= '0;
        sum_ticks[i]   <= '0;
        least_ticks[i] <= '1;
        most_ticks[i]  <= '0;
        hit_count[i]   <= '0;
      end
      frame_start_user   <= '0;
      frame_start_system <= '0;
      system_sum         <= '0;
      system_least       <= '1;
      system_most        <= '0;
      frame_counter      <= '0;
      rep_idx            <= '0;
      result_strobe      <= 1'b0;
    end else begin
      result_strobe <= cmd.report;

      if (cmd.update) begin
        unique case (op_q)
          OP_BEGIN: begin
            if (sec_ok_q && !open_flag[idx_q]) begin
              open_flag[idx_q] <= 1'b1;
              open_time[idx_q] <= ut_q;
            end
          end
          OP_END: begin
            if (sec_ok_q && open_flag[idx_q]) begin
              open_flag[idx_q] <= 1'b0;
              open_time[idx_q] <= '0;
            end
          end
          OP_FRAME_BEGIN: begin
            frame_start_user   <= ut_q;
            frame_start_system <= st_q;
          end
          OP_FRAME_END: begin
            system_sum <= system_sum + SUM_W'(ds_q);
            if (ds_q < system_least) system_least <= ds_q;
            if (ds_q > system_most) system_most <= ds_q;
            frame_counter <= counter_inc;
          end
          default: ;
        endcase

        if (add_en) begin
          sum_ticks[idx_q] <= sum_next;
          hit_count[idx_q] <= hit_count[idx_q] + 32'd1;
          if (dt_q < least_ticks[idx_q]) least_ticks[idx_q] <= dt_q;
          if (dt_q > most_ticks[idx_q]) most_ticks[idx_q] <= dt_q;
        end
      end

      if (cmd.report) begin
        if (status.report_last) begin
          // The system record closes the report; the batch starts over.
          for (int i = 0; i < NUM_SECTIONS; i++) begin
            open_flag[i]   <= 1'b0;
            open_time[i]   <= '0;
            sum_ticks[i]   <= '0;
            least_ticks[i] <= '1;
            most_ticks[i]  <= '0;
            hit_count[i]   <= '0;
          end
          system_sum    <= '0;
          system_least  <= '1;
          system_most   <= '0;
          frame_counter <= '0;
          rep_idx       <= '0;
        end else begin
          rep_idx <= rep_idx + RW'(1);
        end
      end
    end
  end

endmodule

### src/stp_checker.sv
`include "section_timing_profiler_macros.svh"

module stp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_strobe,
  input logic last_record
);

  // An accepted transfer always occupies the block for the following cycle.
  `STP_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not set after accept")
  // Records of a report come in an unbroken run that ends with the last one.
  `STP_ASSERT_NEXT(a_report_run, clk, rst, result_strobe && !last_record, result_strobe, "report run broken")
  // Nothing follows the final record directly.
  `STP_ASSERT_NEXT(a_report_end, clk, rst, result_strobe && last_record, !result_strobe, "record after final record")
  // A record only appears while a report is in progress.
  `STP_ASSERT_SAME(a_strobe_busy, clk, rst, result_strobe, $past(busy), "record without busy period")

endmodule

bind section_timing_profiler stp_checker u_stp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .last_record   (last_record)
);
